// ===== hdl/bytecode_register_vm_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bytecode VM execute unit
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BYTECODE_REGISTER_VM_EXECUTE_DEFINES_SVH
`define BYTECODE_REGISTER_VM_EXECUTE_DEFINES_SVH

// same-cycle implication
`define BVM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvm assertion failed");

// next-cycle implication
`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvm assertion failed");

`endif

// ===== hdl/bvm_pkg.sv =====
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared codes, widths and control structs of the bytecode VM execute unit.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int WORD_W = 32;
  localparam int DCNT_W = 5;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  localparam logic [2:0] STAT_RUN  = 3'd0;
  localparam logic [2:0] STAT_END  = 3'd1;
  localparam logic [2:0] STAT_UNK  = 3'd2;
  localparam logic [2:0] STAT_EXC  = 3'd3;
  localparam logic [2:0] STAT_IDLE = 3'd4;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_MOVE    = 8'h01;
  localparam logic [7:0] OP_CONST_W = 8'h03;
  localparam logic [7:0] OP_CONST_L = 8'h04;
  localparam logic [7:0] OP_CONST_S = 8'h05;
  localparam logic [7:0] OP_ADD     = 8'h10;
  localparam logic [7:0] OP_SUB     = 8'h11;
  localparam logic [7:0] OP_MUL     = 8'h12;
  localparam logic [7:0] OP_DIV     = 8'h13;
  localparam logic [7:0] OP_REM     = 8'h14;
  localparam logic [7:0] OP_AND     = 8'h15;
  localparam logic [7:0] OP_OR      = 8'h16;
  localparam logic [7:0] OP_XOR     = 8'h17;
  localparam logic [7:0] OP_SHL     = 8'h18;
  localparam logic [7:0] OP_SHR     = 8'h19;
  localparam logic [7:0] OP_USHR    = 8'h1A;
  localparam logic [7:0] OP_NEG     = 8'h1B;
  localparam logic [7:0] OP_NOT     = 8'h1D;
  localparam logic [7:0] OP_CMP     = 8'h30;
  localparam logic [7:0] OP_IF_EQ   = 8'h40;
  localparam logic [7:0] OP_IF_LE   = 8'h45;
  localparam logic [7:0] OP_IF_LEZ  = 8'h4B;
  localparam logic [7:0] OP_GOTO    = 8'h50;
  localparam logic [7:0] OP_INVOKE  = 8'h70;
  localparam logic [7:0] OP_RET_V   = 8'hA0;
  localparam logic [7:0] OP_RET     = 8'hA1;
  localparam logic [7:0] OP_JUNK    = 8'hFE;
  localparam logic [7:0] OP_HALT    = 8'hFF;

  // condition codes: low nibble of the compare-branch opcodes
  localparam logic [3:0] CC_EQ  = 4'd0;
  localparam logic [3:0] CC_NE  = 4'd1;
  localparam logic [3:0] CC_LT  = 4'd2;
  localparam logic [3:0] CC_GE  = 4'd3;
  localparam logic [3:0] CC_GT  = 4'd4;
  localparam logic [3:0] CC_LE  = 4'd5;
  localparam logic [3:0] CC_EQZ = 4'd6;
  localparam logic [3:0] CC_NEZ = 4'd7;
  localparam logic [3:0] CC_LTZ = 4'd8;
  localparam logic [3:0] CC_GEZ = 4'd9;
  localparam logic [3:0] CC_GTZ = 4'd10;

  typedef enum logic [1:0] {
    RD_B = 2'd0,
    RD_C = 2'd1,
    RD_A = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    latch_b;
    logic    latch_c;
    logic    div_start;
    logic    commit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/bvm_div.sv =====
// ----------------------------------------------------------------------------
// bvm_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module bvm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [bvm_pkg::DCNT_W-1:0] cnt;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dsr;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted = {rem_q, quo_q[31]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == bvm_pkg::DCNT_W'(bvm_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
      dsr   <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // sign fix: magnitude 2^31 negates back to the minimum value
  assign quotient  = neg_q ? (32'd0 - quo_q) : quo_q;
  assign remainder = neg_r ? (32'd0 - rem_q) : rem_q;

endmodule

// ===== hdl/bvm_dpath.sv =====
// ----------------------------------------------------------------------------
// bvm_dpath
// Register file, operand latches, execute logic, machine state and output.
// ----------------------------------------------------------------------------
module bvm_dpath #(
  parameter int NUM_REGS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  bvm_pkg::cmd_t      cmd,
  output bvm_pkg::sts_t      sts,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_opcode,
  input  logic [31:0]        in_operand_a,
  input  logic [31:0]        in_operand_b,
  input  logic [31:0]        in_operand_c,
  input  logic [63:0]        in_load_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        out_next_pc,
  output logic [2:0]         out_status,
  output logic [63:0]        out_ret_val
);

  localparam int RIDX_W = $clog2(NUM_REGS);

  logic [63:0]        regs [NUM_REGS];
  logic [NUM_REGS-1:0] rvalid;
  logic [63:0]        rd_data;
  logic               rd_vld;
  logic [63:0]        rd_val;
  logic [RIDX_W-1:0]  ridx_tab [256];
  logic [RIDX_W-1:0]  ia, ib, ic, rd_addr;

  logic [1:0]  kind;
  logic [7:0]  op;
  logic [31:0] a_q, b_q, c_q;
  logic [63:0] ld_q;
  logic [63:0] vb, vc;

  logic [31:0] pc;
  logic        run;
  logic [63:0] rv;
  logic [15:0] plen;

  logic [31:0] pend_pc;
  logic [2:0]  pend_st;
  logic [63:0] pend_rv;

  logic [31:0] pc_next;
  logic        run_next;
  logic [63:0] rv_next;
  logic [2:0]  st;
  logic        wr_en;
  logic [63:0] wr_data;
  logic        need_div;

  logic        div_busy, div_done;
  logic [31:0] div_q, div_r;

  genvar g;
  for (g = 0; g < 256; g++) begin : g_ridx
    assign ridx_tab[g] = RIDX_W'(g % NUM_REGS);
  end

  assign ia = ridx_tab[a_q[7:0]];
  assign ib = ridx_tab[b_q[7:0]];
  assign ic = ridx_tab[c_q[7:0]];

  always_comb begin
    case (cmd.rd_sel)
      bvm_pkg::RD_B: rd_addr = ib;
      bvm_pkg::RD_C: rd_addr = ic;
      default:       rd_addr = ia;
    endcase
  end

  assign rd_val = rd_vld ? rd_data : 64'd0;

  // register file: one read, one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= regs[rd_addr];
    end
    if (cmd.commit && wr_en) begin
      regs[ia] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld <= rvalid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
    end else if (cmd.commit && wr_en) begin
      rvalid[ia] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind <= in_kind;
      op   <= in_opcode;
      a_q  <= in_operand_a;
      b_q  <= in_operand_b;
      c_q  <= in_operand_c;
      ld_q <= in_load_value;
    end
    if (cmd.latch_b) begin
      vb <= rd_val;
    end
    if (cmd.latch_c) begin
      vc <= rd_val;
    end
  end

  bvm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (vb[31:0]),
    .divisor   (vc[31:0]),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic taken(input logic [3:0] cc, input logic signed [31:0] x,
                                 input logic signed [31:0] y);
    case (cc)
      bvm_pkg::CC_EQ, bvm_pkg::CC_EQZ: return x == y;
      bvm_pkg::CC_NE, bvm_pkg::CC_NEZ: return x != y;
      bvm_pkg::CC_LT, bvm_pkg::CC_LTZ: return x < y;
      bvm_pkg::CC_GE, bvm_pkg::CC_GEZ: return x >= y;
      bvm_pkg::CC_GT, bvm_pkg::CC_GTZ: return x > y;
      default:                         return x <= y;
    endcase
  endfunction

  always_comb begin
    logic [31:0] pc1;
    logic [31:0] mul_lo;
    logic [31:0] off;
    logic [31:0] y;
    logic        chk;
    logic        two_op;
    pc1      = pc + 32'd1;
    mul_lo   = vb[31:0] * vc[31:0];
    two_op   = (op <= bvm_pkg::OP_IF_LE);
    off      = two_op ? c_q : b_q;
    y        = two_op ? vb[31:0] : 32'd0;
    chk      = 1'b0;
    pc_next  = pc;
    run_next = run;
    rv_next  = rv;
    st       = bvm_pkg::STAT_RUN;
    wr_en    = 1'b0;
    wr_data  = ld_q;
    need_div = 1'b0;
    case (kind)
      bvm_pkg::KIND_START: begin
        pc_next = '0;
        rv_next = '0;
        if (plen == 16'd0) begin
          run_next = 1'b0;
          st       = bvm_pkg::STAT_END;
        end else begin
          run_next = 1'b1;
        end
      end
      bvm_pkg::KIND_EXEC: begin
        if (!run) begin
          st = bvm_pkg::STAT_IDLE;
        end else if (pc[31] || pc > {16'd0, plen}) begin
          run_next = 1'b0;
          st       = bvm_pkg::STAT_EXC;
        end else if (pc == {16'd0, plen}) begin
          run_next = 1'b0;
          st       = bvm_pkg::STAT_END;
        end else begin
          pc_next = pc1;
          chk     = 1'b1;
          wr_en   = 1'b1;
          case (op)
            bvm_pkg::OP_NOP, bvm_pkg::OP_INVOKE, bvm_pkg::OP_JUNK: wr_en = 1'b0;
            bvm_pkg::OP_MOVE:    wr_data = vb;
            bvm_pkg::OP_CONST_S: wr_data = {{56{b_q[7]}}, b_q[7:0]};
            bvm_pkg::OP_CONST_W: wr_data = sx32(b_q);
            bvm_pkg::OP_CONST_L: wr_data = {c_q, b_q};
            bvm_pkg::OP_ADD:     wr_data = sx32(vb[31:0] + vc[31:0]);
            bvm_pkg::OP_SUB:     wr_data = sx32(vb[31:0] - vc[31:0]);
            bvm_pkg::OP_MUL:     wr_data = sx32(mul_lo);
            bvm_pkg::OP_DIV, bvm_pkg::OP_REM: begin
              if (vc[31:0] == 32'd0) begin
                wr_en    = 1'b0;
                chk      = 1'b0;
                run_next = 1'b0;
                st       = bvm_pkg::STAT_EXC;
              end else begin
                need_div = 1'b1;
                wr_data  = sx32((op == bvm_pkg::OP_DIV) ? div_q : div_r);
              end
            end
            bvm_pkg::OP_AND:  wr_data = vb & vc;
            bvm_pkg::OP_OR:   wr_data = vb | vc;
            bvm_pkg::OP_XOR:  wr_data = vb ^ vc;
            bvm_pkg::OP_SHL:  wr_data = sx32(vb[31:0] << vc[4:0]);
            bvm_pkg::OP_SHR:  wr_data = sx32(32'($signed(vb[31:0]) >>> vc[4:0]));
            bvm_pkg::OP_USHR: wr_data = {32'd0, vb[31:0] >> vc[4:0]};
            bvm_pkg::OP_NEG:  wr_data = sx32(32'd0 - vb[31:0]);
            bvm_pkg::OP_NOT:  wr_data = ~vb;
            bvm_pkg::OP_CMP: begin
              if ($signed(vb) > $signed(vc)) begin
                wr_data = 64'd1;
              end else if ($signed(vb) < $signed(vc)) begin
                wr_data = '1;
              end else begin
                wr_data = 64'd0;
              end
            end
            bvm_pkg::OP_GOTO: begin
              wr_en   = 1'b0;
              pc_next = pc1 + a_q;
            end
            bvm_pkg::OP_RET: begin
              wr_en    = 1'b0;
              chk      = 1'b0;
              rv_next  = rd_val;
              run_next = 1'b0;
              st       = bvm_pkg::STAT_END;
            end
            bvm_pkg::OP_RET_V, bvm_pkg::OP_HALT: begin
              wr_en    = 1'b0;
              chk      = 1'b0;
              run_next = 1'b0;
              st       = bvm_pkg::STAT_END;
            end
            default: begin
              wr_en = 1'b0;
              if (op >= bvm_pkg::OP_IF_EQ && op <= bvm_pkg::OP_IF_LEZ) begin
                if (taken(op[3:0], rd_val[31:0], y)) begin
                  pc_next = pc1 + off;
                end
              end else begin
                chk      = 1'b0;
                run_next = 1'b0;
                st       = bvm_pkg::STAT_UNK;
              end
            end
          endcase
          if (chk) begin
            if (pc_next[31] || pc_next > {16'd0, plen}) begin
              run_next = 1'b0;
              st       = bvm_pkg::STAT_EXC;
            end else if (pc_next == {16'd0, plen}) begin
              run_next = 1'b0;
              st       = bvm_pkg::STAT_END;
            end
          end
        end
      end
      default: begin
        wr_en = (kind == bvm_pkg::KIND_LOAD);
        st    = run ? bvm_pkg::STAT_RUN : bvm_pkg::STAT_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      run  <= 1'b0;
      rv   <= '0;
      plen <= '0;
    end else begin
      if (cfg_wr_en) begin
        plen <= cfg_wr_data;
      end
      if (cmd.commit) begin
        pc  <= pc_next;
        run <= run_next;
        rv  <= rv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_pc <= pc_next;
      pend_st <= st;
      pend_rv <= (st == bvm_pkg::STAT_END) ? rv_next : 64'd0;
    end
    if (cmd.out_load) begin
      out_next_pc <= pend_pc;
      out_status  <= pend_st;
      out_ret_val <= pend_rv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

// ===== hdl/bvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvm_ctrl
// Sequencer: capture, three register reads, execute, divide when needed, hand off.
// ----------------------------------------------------------------------------
module bvm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bvm_pkg::sts_t sts,
  output bvm_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDB  = 7'b0000010,
    S_RDC  = 7'b0000100,
    S_RDA  = 7'b0001000,
    S_EXEC = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = bvm_pkg::RD_B;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_RDB;
        end
      end
      S_RDB: begin
        cmd.rd_en  = 1'b1;
        state_next = S_RDC;
      end
      S_RDC: begin
        cmd.latch_b = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = bvm_pkg::RD_C;
        state_next  = S_RDA;
      end
      S_RDA: begin
        cmd.latch_c = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = bvm_pkg::RD_A;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/bytecode_register_vm_execute.sv =====
// A result is registered through the read states, the execute state and the output register,
// and waits there until the output is free. Items are taken one at a time: no new item is
// accepted before the last is handed off; divide and remainder add 32 quotient steps.
// The pace is set by three serial reads of the register file, which has one read port.
// Reset clears pc, run state, return value and program length; register file valid
// bits clear at once, so unwritten registers read as zero with no clearing pass.
// ----------------------------------------------------------------------------
// bytecode_register_vm_execute
// Execute unit of a register bytecode machine: load, start and execute items.
// ----------------------------------------------------------------------------
`include "bytecode_register_vm_execute_defines.svh"

module bytecode_register_vm_execute #(
  parameter int NUM_REGS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,    // program_length
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[7:0], operand_a[39:8], operand_b[71:40], operand_c[103:72],
  // load_value[167:104]
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,        // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,        // next_pc[31:0], result value[95:32]
  output logic [2:0]   m_tuser         // status
);

  bvm_pkg::cmd_t cmd;
  bvm_pkg::sts_t sts;

  logic [31:0] next_pc;
  logic [63:0] ret_word;

  // sequencer: holds one item at a time, advances through the read slots
  bvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: unpack the transfer, execute, hold the result until taken
  bvm_dpath #(
    .NUM_REGS (NUM_REGS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_kind       (s_tuser),
    .in_opcode     (s_tdata[7:0]),
    .in_operand_a  (s_tdata[39:8]),
    .in_operand_b  (s_tdata[71:40]),
    .in_operand_c  (s_tdata[103:72]),
    .in_load_value (s_tdata[167:104]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .out_next_pc   (next_pc),
    .out_status    (m_tuser),
    .out_ret_val   (ret_word)
  );

  assign m_tdata = {ret_word, next_pc};

  // no new item while the divider is iterating
  `BVM_ASSERT_IMPL(a_no_accept_in_div, clk, rst, sts.div_busy, !s_tready)
  // one item in flight: an accepted transfer drops ready next cycle
  `BVM_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // the output register is loaded only when empty or being drained
  `BVM_ASSERT_IMPL(a_out_load_free, clk, rst, cmd.out_load, !m_tvalid || m_tready)

endmodule
